// ===== hw/rtl/incremental_deadlock_detector_macros.svh =====
// assertion macros shared by the checker
`ifndef INCREMENTAL_DEADLOCK_DETECTOR_MACROS_SVH
`define INCREMENTAL_DEADLOCK_DETECTOR_MACROS_SVH

// same-cycle implication on the port clock
`define IDD_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deadlock detector port check failed");

// next-cycle implication on the port clock
`define IDD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deadlock detector port check failed");

`endif

// ===== hw/rtl/idd_pkg.sv =====
package idd_pkg;

    // fixed field widths of the item formats
    localparam int ID_BITS    = 5;
    localparam int MASK_BITS  = 32;
    localparam int INDEX_BITS = 16;

    // one edge of the allocation graph
    typedef struct packed {
        logic                  start_new;
        logic                  edge_is_assign;
        logic [ID_BITS-1:0]    process_id;
        logic [ID_BITS-1:0]    resource_id;
    } idd_arc_t;

    // one result item
    typedef struct packed {
        logic                  deadlock_found;
        logic [MASK_BITS-1:0]  deadlocked_mask;
        logic [INDEX_BITS-1:0] deadlock_edge_index;
    } idd_result_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_WR_RD,
        S_WR_WB,
        S_SCAN_START,
        S_SCAN,
        S_FINISH
    } idd_state_t;

endpackage

// ===== hw/rtl/incremental_deadlock_detector.sv =====
// an in-range item is written into its row, then reduction passes over all rows repeat until
// one removes nothing (1 up to NUM_PROCESSES + NUM_RESOURCES + 1 passes); one row is tested a cycle
// by the single shared row compare unit; a new item is taken only once the last result is loaded
// an item after a latched deadlock, with start_new clear, skips the scan; results wait in an output register
// reset (async, active low) clears the graph row valid bits, counters and latch at once
module incremental_deadlock_detector
    import idd_pkg::*;
#(
    parameter int NUM_PROCESSES   = 32,
    parameter int NUM_RESOURCES   = 32,
    parameter int EDGE_INDEX_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        arc_valid,
    output logic        arc_stall,
    input  idd_arc_t    arc_data,
    output logic        result_valid,
    input  logic        result_stall,
    output idd_result_t result_data
);

    localparam int NP = NUM_PROCESSES;
    localparam int NR = NUM_RESOURCES;
    localparam int NN = NP + NR;
    localparam int PW = $clog2(NP);
    localparam int RW = $clog2(NR);
    localparam int IW = $clog2(NN);
    localparam int W  = (NP > NR) ? NP : NR;
    localparam int EW = EDGE_INDEX_BITS;

    idd_state_t state_reg, state_next;

    logic [PW-1:0] pid_reg, pid_next;
    logic [RW-1:0] rid_reg, rid_next;
    logic          assign_reg, assign_next;

    logic [NP-1:0] valid_p_reg, valid_p_next;
    logic [NR-1:0] valid_r_reg, valid_r_next;
    logic [NP-1:0] alive_p_reg, alive_p_next;
    logic [NR-1:0] alive_r_reg, alive_r_next;
    logic [NP-1:0] gone_p_reg, gone_p_next;
    logic [NR-1:0] gone_r_reg, gone_r_next;

    logic [EW-1:0] edge_count_reg, edge_count_next;
    logic [EW-1:0] this_index_reg, this_index_next;
    logic          latched_reg, latched_next;
    logic [NP-1:0] latched_mask_reg, latched_mask_next;
    logic [EW-1:0] latched_index_reg, latched_index_next;
    logic          changed_reg, changed_next;
    logic [IW-1:0] idx_reg, idx_next;

    logic          out_valid_reg, out_valid_next;
    idd_result_t   out_data_reg, out_data_next;

    // graph storage, one row per process and per resource
    logic [NR-1:0] req_mem  [NP];
    logic [NP-1:0] hold_mem [NR];
    logic [NR-1:0] req_rd_reg;
    logic [NP-1:0] hold_rd_reg;
    logic          req_rv_reg;
    logic          hold_rv_reg;

    logic [PW-1:0] req_addr;
    logic [RW-1:0] hold_addr;
    logic          req_we;
    logic          hold_we;
    logic [NR-1:0] req_wdata;
    logic [NP-1:0] hold_wdata;

    logic          arc_accept;
    logic          in_range;
    logic          eff_latched;
    logic          finish_load;
    logic          scan_last;
    logic [IW-1:0] rd_k;
    logic [IW-1:0] rd_hk;
    logic [IW-1:0] cur_hk;
    logic [NR-1:0] req_row;
    logic [NP-1:0] hold_row;
    logic          is_proc;
    logic [PW-1:0] cur_p;
    logic [RW-1:0] cur_r;
    logic [W-1:0]  cmp_row;
    logic [W-1:0]  cmp_mask;
    logic          blocked;
    logic          cand;
    logic          hit;
    logic [NP-1:0] left_mask;

    // handshake
    assign arc_stall    = (state_reg != S_IDLE);
    assign arc_accept   = arc_valid && (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    assign in_range    = (int'(arc_data.process_id) < NP) && (int'(arc_data.resource_id) < NR);
    assign eff_latched = latched_reg && !arc_data.start_new;
    assign finish_load = (state_reg == S_FINISH) && (!out_valid_reg || !result_stall);

    // scan position and read addresses
    assign scan_last = (idx_reg == IW'(NN - 1));
    assign rd_k      = (state_reg == S_SCAN && !scan_last) ? idx_reg + IW'(1) : '0;
    assign rd_hk     = rd_k - IW'(NP);
    assign cur_hk    = idx_reg - IW'(NP);
    assign req_addr  = (state_reg == S_WR_RD) ? pid_reg :
                       ((rd_k < IW'(NP)) ? rd_k[PW-1:0] : '0);
    assign hold_addr = (state_reg == S_WR_RD) ? rid_reg :
                       ((rd_k >= IW'(NP)) ? rd_hk[RW-1:0] : '0);

    // rows that were never written since the last clear read as empty
    assign req_row  = req_rv_reg  ? req_rd_reg  : '0;
    assign hold_row = hold_rv_reg ? hold_rd_reg : '0;

    // shared row compare unit
    assign is_proc  = (idx_reg < IW'(NP));
    assign cur_p    = idx_reg[PW-1:0];
    assign cur_r    = cur_hk[RW-1:0];
    assign cmp_row  = is_proc ? W'(req_row) : W'(hold_row);
    assign cmp_mask = is_proc ? W'(alive_r_reg & ~gone_r_reg) : W'(alive_p_reg & ~gone_p_reg);
    assign blocked  = |(cmp_row & cmp_mask);
    assign cand     = is_proc ? (alive_p_reg[cur_p] && !gone_p_reg[cur_p]) :
                                (alive_r_reg[cur_r] && !gone_r_reg[cur_r]);
    assign hit      = (state_reg == S_SCAN) && cand && !blocked;
    assign left_mask = alive_p_reg & ~gone_p_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (arc_valid)
                begin
                    if (eff_latched)
                        state_next = S_FINISH;
                    else if (in_range)
                        state_next = S_WR_RD;
                    else
                        state_next = S_SCAN_START;
                end
            end
            S_WR_RD:      state_next = S_WR_WB;
            S_WR_WB:      state_next = S_SCAN_START;
            S_SCAN_START: state_next = S_SCAN;
            S_SCAN:
            begin
                if (scan_last && !(changed_reg || hit))
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !result_stall)
                    state_next = S_IDLE;
            end
            default:      state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pid_next           = pid_reg;
        rid_next           = rid_reg;
        assign_next        = assign_reg;
        valid_p_next       = valid_p_reg;
        valid_r_next       = valid_r_reg;
        alive_p_next       = alive_p_reg;
        alive_r_next       = alive_r_reg;
        gone_p_next        = gone_p_reg;
        gone_r_next        = gone_r_reg;
        edge_count_next    = edge_count_reg;
        this_index_next    = this_index_reg;
        latched_next       = latched_reg;
        latched_mask_next  = latched_mask_reg;
        latched_index_next = latched_index_reg;
        changed_next       = changed_reg;
        idx_next           = idx_reg;
        out_valid_next     = out_valid_reg;
        out_data_next      = out_data_reg;
        req_we             = 1'b0;
        hold_we            = 1'b0;
        req_wdata          = req_row | (NR'(1) << rid_reg);
        hold_wdata         = hold_row | (NP'(1) << pid_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (arc_accept)
                begin
                    pid_next    = PW'(arc_data.process_id);
                    rid_next    = RW'(arc_data.resource_id);
                    assign_next = arc_data.edge_is_assign;
                    // a new list clears the graph before this edge
                    if (arc_data.start_new)
                    begin
                        valid_p_next       = '0;
                        valid_r_next       = '0;
                        alive_p_next       = '0;
                        alive_r_next       = '0;
                        edge_count_next    = '0;
                        latched_next       = 1'b0;
                        latched_mask_next  = '0;
                        latched_index_next = '0;
                    end
                    if (!eff_latched)
                    begin
                        this_index_next = arc_data.start_new ? '0 : edge_count_reg;
                        if (arc_data.start_new)
                            edge_count_next = EW'(1);
                        else if (edge_count_reg != '1)
                            edge_count_next = edge_count_reg + EW'(1);
                        if (in_range)
                        begin
                            alive_p_next = (arc_data.start_new ? '0 : alive_p_reg)
                                           | (NP'(1) << arc_data.process_id);
                            alive_r_next = (arc_data.start_new ? '0 : alive_r_reg)
                                           | (NR'(1) << arc_data.resource_id);
                        end
                    end
                end
            end
            S_WR_RD:
            begin
            end
            S_WR_WB:
            begin
                // set the edge bit in its row
                if (assign_reg)
                begin
                    hold_we               = 1'b1;
                    valid_r_next[rid_reg] = 1'b1;
                end
                else
                begin
                    req_we                = 1'b1;
                    valid_p_next[pid_reg] = 1'b1;
                end
            end
            S_SCAN_START:
            begin
                gone_p_next  = '0;
                gone_r_next  = '0;
                changed_next = 1'b0;
                idx_next     = '0;
            end
            S_SCAN:
            begin
                // remove a node with no outgoing edge to a present node
                if (hit)
                begin
                    if (is_proc)
                        gone_p_next[cur_p] = 1'b1;
                    else
                        gone_r_next[cur_r] = 1'b1;
                end
                if (scan_last)
                begin
                    idx_next     = '0;
                    changed_next = 1'b0;
                    if (!(changed_reg || hit) && (left_mask != '0))
                    begin
                        latched_next       = 1'b1;
                        latched_mask_next  = left_mask;
                        latched_index_next = this_index_reg;
                    end
                end
                else
                begin
                    idx_next     = idx_reg + IW'(1);
                    changed_next = changed_reg || hit;
                end
            end
            S_FINISH:
            begin
            end
            default:
            begin
            end
        endcase

        // output register
        if (finish_load)
        begin
            out_valid_next = 1'b1;
            out_data_next.deadlock_found = latched_reg;
            out_data_next.deadlocked_mask = latched_reg ? MASK_BITS'(latched_mask_reg) : '0;
            out_data_next.deadlock_edge_index = latched_reg ? INDEX_BITS'(latched_index_reg)
                                                            : INDEX_BITS'(edge_count_reg);
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            valid_p_reg       <= '0;
            valid_r_reg       <= '0;
            alive_p_reg       <= '0;
            alive_r_reg       <= '0;
            gone_p_reg        <= '0;
            gone_r_reg        <= '0;
            edge_count_reg    <= '0;
            latched_reg       <= 1'b0;
            latched_mask_reg  <= '0;
            latched_index_reg <= '0;
            changed_reg       <= 1'b0;
            idx_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            valid_p_reg       <= valid_p_next;
            valid_r_reg       <= valid_r_next;
            alive_p_reg       <= alive_p_next;
            alive_r_reg       <= alive_r_next;
            gone_p_reg        <= gone_p_next;
            gone_r_reg        <= gone_r_next;
            edge_count_reg    <= edge_count_next;
            latched_reg       <= latched_next;
            latched_mask_reg  <= latched_mask_next;
            latched_index_reg <= latched_index_next;
            changed_reg       <= changed_next;
            idx_reg           <= idx_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pid_reg        <= pid_next;
        rid_reg        <= rid_next;
        assign_reg     <= assign_next;
        this_index_reg <= this_index_next;
        out_data_reg   <= out_data_next;
    end

    // row memories with registered read
    always_ff @(posedge clk)
    begin
        if (req_we)
            req_mem[pid_reg] <= req_wdata;
        if (hold_we)
            hold_mem[rid_reg] <= hold_wdata;
        req_rd_reg  <= req_mem[req_addr];
        hold_rd_reg <= hold_mem[hold_addr];
        req_rv_reg  <= valid_p_reg[req_addr];
        hold_rv_reg <= valid_r_reg[hold_addr];
    end

endmodule

// ===== hw/rtl/idd_checker.sv =====
`include "incremental_deadlock_detector_macros.svh"

module idd_checker
    import idd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        arc_valid,
    input logic        arc_stall,
    input idd_arc_t    arc_data,
    input logic        result_valid,
    input logic        result_stall,
    input idd_result_t result_data
);

    // a waiting result item holds
    `IDD_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result_data))

    // the block is busy right after taking an item
    `IDD_ASSERT_NEXT(a_busy_after_accept, arc_valid && !arc_stall, arc_stall)

    // no mask is shown without a deadlock
    `IDD_ASSERT_SAME(a_mask_needs_deadlock, result_valid && !result_data.deadlock_found, result_data.deadlocked_mask == '0)

    // a result item never carries unknown bits
    `IDD_ASSERT_SAME(a_result_known, result_valid, !$isunknown(result_data))

endmodule

bind incremental_deadlock_detector idd_checker u_idd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .arc_valid    (arc_valid),
    .arc_stall    (arc_stall),
    .arc_data     (arc_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
);

// ===== tb/sv/testbench.sv =====
module testbench
    import idd_pkg::*;
();

    // shadow of the allocation graph, one copy per side
    typedef struct packed {
        logic [31:0][31:0] req_rows;    // req_rows[p][r]: process p waits on resource r
        logic [31:0][31:0] hold_rows;   // hold_rows[r][p]: resource r held by process p
        logic [15:0]       arcs_taken;
        logic              latched;
        logic [31:0]       latch_mask;
        logic [15:0]       latch_index;
        logic [31:0]       live_procs;
        logic [31:0]       live_res;
    } graph_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        arc_valid = 1'b0;
    logic        arc_stall;
    idd_arc_t    arc_data = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    idd_result_t result_data;

    idd_arc_t    pending_arcs[$];
    idd_result_t predicted_verdicts[$];
    graph_t      plan_graph;
    graph_t      model_graph;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;
    int          fault_count = 0;
    int          live_arc_count = 0;

    incremental_deadlock_detector DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .arc_valid    (arc_valid),
        .arc_stall    (arc_stall),
        .arc_data     (arc_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // clock generation
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // unless a deadlock is latched: add one arc, peel off sink nodes until nothing changes, report what is left
    function automatic void graph_take_arc(inout graph_t g, input idd_arc_t a,
                                           output idd_result_t verdict);
        logic [31:0] gone_p;
        logic [31:0] gone_r;
        logic [31:0] left;
        logic [15:0] this_index;
        logic        changed;
        if (a.start_new)
            g = '0;
        if (!g.latched)
        begin
            this_index = g.arcs_taken;
            g.live_procs[a.process_id] = 1'b1;
            g.live_res[a.resource_id]  = 1'b1;
            if (a.edge_is_assign)
                g.hold_rows[a.resource_id][a.process_id] = 1'b1;
            else
                g.req_rows[a.process_id][a.resource_id] = 1'b1;
            if (g.arcs_taken != 16'hFFFF)
                g.arcs_taken = g.arcs_taken + 16'd1;
            gone_p  = '0;
            gone_r  = '0;
            changed = 1'b1;
            while (changed)
            begin
                changed = 1'b0;
                for (int p = 0; p < 32; p++)
                begin
                    if (g.live_procs[p] && !gone_p[p] &&
                        (g.req_rows[p] & g.live_res & ~gone_r) == '0)
                    begin
                        gone_p[p] = 1'b1;
                        changed   = 1'b1;
                    end
                end
                for (int r = 0; r < 32; r++)
                begin
                    if (g.live_res[r] && !gone_r[r] &&
                        (g.hold_rows[r] & g.live_procs & ~gone_p) == '0)
                    begin
                        gone_r[r] = 1'b1;
                        changed   = 1'b1;
                    end
                end
            end
            left = g.live_procs & ~gone_p;
            if (left != '0)
            begin
                g.latched     = 1'b1;
                g.latch_mask  = left;
                g.latch_index = this_index;
            end
        end
        if (g.latched)
        begin
            verdict.deadlock_found      = 1'b1;
            verdict.deadlocked_mask     = g.latch_mask;
            verdict.deadlock_edge_index = g.latch_index;
        end
        else
        begin
            verdict.deadlock_found      = 1'b0;
            verdict.deadlocked_mask     = '0;
            verdict.deadlock_edge_index = g.arcs_taken;
        end
    endfunction

    // queue an arc for the driver; every queued arc is counted
    task automatic queue_arc(input logic sn, input logic asg, input logic [4:0] pid,
                             input logic [4:0] rid);
        idd_arc_t    a;
        idd_result_t unused;
        a.start_new      = sn;
        a.edge_is_assign = asg;
        a.process_id     = pid;
        a.resource_id    = rid;
        live_arc_count++;
        graph_take_arc(plan_graph, a, unused);
        pending_arcs.insert(pending_arcs.size(), a);
    endtask

    function automatic logic [4:0] pick_id(input int base, input int span);
        return 5'(base + $urandom_range(0, span));
    endfunction

    // one list: mostly well-formed arcs over a narrow id window, some noise
    task automatic random_list();
        int span_p;
        int span_r;
        int base_p;
        int base_r;
        int length;
        int tail;
        int i;
        span_p = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : 31;
        span_r = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 5) : 31;
        base_p = $urandom_range(0, 31 - span_p);
        base_r = $urandom_range(0, 31 - span_r);
        length = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 20) : $urandom_range(20, 60);
        i = 0;
        while (i < length && (i == 0 || !plan_graph.latched))
        begin
            if ($urandom_range(0, 9) == 0)
                queue_arc(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            else
                queue_arc(i == 0, 1'($urandom_range(0, 1)),
                          pick_id(base_p, span_p), pick_id(base_r, span_r));
            i++;
        end
        // a few arcs against the latched result
        if (plan_graph.latched)
        begin
            tail = $urandom_range(0, 3);
            for (int k = 0; k < tail; k++)
                queue_arc(1'b0, 1'($urandom_range(0, 1)),
                          5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        end
    endtask

    // hold off until every queued arc has been sent and answered
    task automatic wait_drained();
        while (pending_arcs.size() != 0 || arc_valid || predicted_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // driver: predict on acceptance, then load the next item or idle
    always @(posedge clk or negedge rst_n)
    begin
        idd_result_t verdict;
        if (!rst_n)
        begin
            arc_valid <= 1'b0;
            arc_data  <= '0;
        end
        else
        begin
            if (arc_valid && !arc_stall)
            begin
                graph_take_arc(model_graph, arc_data, verdict);
                predicted_verdicts.insert(predicted_verdicts.size(), verdict);
            end
            if (!arc_valid || !arc_stall)
            begin
                if (pending_arcs.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    arc_valid <= 1'b1;
                    arc_data  <= pending_arcs.pop_front();
                end
                else
                    arc_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each accepted result item with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        idd_result_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (predicted_verdicts.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected result item: found=%0d mask=%h index=%0d",
                                 result_data.deadlock_found, result_data.deadlocked_mask,
                                 result_data.deadlock_edge_index);
                end
                else
                begin
                    want = predicted_verdicts.pop_front();
                    if (result_data.deadlock_found != want.deadlock_found ||
                        result_data.deadlocked_mask != want.deadlocked_mask ||
                        result_data.deadlock_edge_index != want.deadlock_edge_index)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("mismatch: expected found=%0d mask=%h index=%0d, got found=%0d mask=%h index=%0d",
                                     want.deadlock_found, want.deadlocked_mask,
                                     want.deadlock_edge_index, result_data.deadlock_found,
                                     result_data.deadlocked_mask,
                                     result_data.deadlock_edge_index);
                    end
                end
            end
            result_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
        end
    end

    // stimulus and end of run
    initial
    begin
        plan_graph  = '0;
        model_graph = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: self loop straight after reset
        queue_arc(1'b0, 1'b0, 5'd0, 5'd0);
        queue_arc(1'b1, 1'b0, 5'd0, 5'd0);
        queue_arc(1'b0, 1'b1, 5'd0, 5'd0);
        // ignored after deadlock
        queue_arc(1'b0, 1'b0, 5'd31, 5'd31);
        queue_arc(1'b0, 1'b1, 5'd17, 5'd3);
        // top ids, duplicate request, chain that reduces away
        queue_arc(1'b1, 1'b0, 5'd31, 5'd31);
        queue_arc(1'b0, 1'b0, 5'd31, 5'd31);
        queue_arc(1'b0, 1'b1, 5'd30, 5'd31);
        queue_arc(1'b0, 1'b1, 5'd30, 5'd31);
        // two-process cycle
        queue_arc(1'b1, 1'b0, 5'd1, 5'd2);
        queue_arc(1'b0, 1'b1, 5'd2, 5'd2);
        queue_arc(1'b0, 1'b0, 5'd2, 5'd1);
        queue_arc(1'b0, 1'b1, 5'd1, 5'd1);
        queue_arc(1'b0, 1'b1, 5'd1, 5'd1);
        // alternating bit patterns
        queue_arc(1'b1, 1'b0, 5'b10101, 5'b01010);
        queue_arc(1'b0, 1'b1, 5'b01010, 5'b10101);
        queue_arc(1'b0, 1'b0, 5'b01010, 5'b01010);
        queue_arc(1'b0, 1'b1, 5'b10101, 5'b01010);
        // cycle over processes 31 and 0, then a third process waits after the deadlock
        queue_arc(1'b1, 1'b1, 5'd31, 5'd0);
        queue_arc(1'b0, 1'b0, 5'd31, 5'd1);
        queue_arc(1'b0, 1'b1, 5'd0, 5'd1);
        queue_arc(1'b0, 1'b0, 5'd0, 5'd0);
        queue_arc(1'b0, 1'b0, 5'd5, 5'd0);
        wait_drained();

        // random phases with different idling
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 48; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 48; end
                default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
            endcase
            while (live_arc_count < 23 + 440 * (ph + 1))
                random_list();
            wait_drained();
        end

        repeat (4400) @(posedge clk);
        if (fault_count == 0 && predicted_verdicts.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial
    begin
        #480_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
